// ===== rtl/core/cit_pkg.sv =====
// cit_pkg: shared constants and types for the counted item table.
// No dependencies; imported by counted_item_table_unit.
`default_nettype none
package cit_pkg;

   localparam int DEPTH_DEFAULT = 32;

   localparam int KEY_W = 8;
   localparam int AMT_W = 8;
   localparam int QTY_W = 7;
   localparam int CAP_W = 6;
   localparam int USED_W = 6;

   localparam logic [QTY_W-1:0] QTY_MAX = 7'd99;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   // Command codes; the unused code behaves as a query.
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [QTY_W-1:0] count;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/core/counted_item_table_unit.sv =====
// counted_item_table_unit: ordered (item id, quantity) table in one RAM.
// Depends on cit_pkg (constants, entry_type).
`default_nettype none
// Usage: pulse start with a command while busy is low. The unit scans the
// table in one single-port-read RAM, reading and then comparing each entry
// in turn until a hit or the last stored entry. A remove that deletes an
// entry then moves each later entry down one slot, reading it and then
// writing it. Exactly one result beat follows each command: rsp_valid is
// high for one cycle and the result must be captured then, since the
// receiver cannot hold it off. busy falls on the same cycle the result
// beat appears, so the next command may start while that beat is on the
// ports. The user must write capacity only while the unit is idle; the
// unit itself does not enforce this. Values above DEPTH act as DEPTH, and
// lowering capacity below the current count keeps existing entries.
module counted_item_table_unit
   import cit_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   // command beat
   input  wire                    start,
   output logic                   busy,
   input  wire  [1:0]             req_command,
   input  wire  [KEY_W-1:0]       req_item_key,
   input  wire  [AMT_W-1:0]       req_amount,
   // result beat
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [QTY_W-1:0]       rsp_quantity,
   output logic [USED_W-1:0]      rsp_entries_used,
   // capacity register
   input  wire                    csr_wr_en,
   input  wire  [CAP_W-1:0]       csr_wr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // RAM address
   localparam int CW = $clog2(DEPTH + 1);                  // entry count
   localparam int XW = (CW > CAP_W) ? CW : CAP_W;          // compare width

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_MISS,
      S_SHF_RD,
      S_SHF_WR
   } state_type;

   state_type        state_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [CW-1:0]    total_ff;
   logic [CW-1:0]    idx_ff;
   logic [1:0]       cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [AMT_W-1:0] amt_ff;

   // table RAM, one write and one registered read per cycle
   entry_type        mem [DEPTH];
   entry_type        rd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   entry_type        mem_wdata;

   // datapath
   logic [CW-1:0]    idx_nxt;
   logic             hit;
   logic             last;
   logic             full;
   logic [8:0]       sum;
   logic [QTY_W-1:0] sum_sat;
   logic [QTY_W-1:0] amt_sat;
   logic             rem_keeps;
   logic [QTY_W-1:0] rem_diff;
   logic             shf_more;
   logic [XW-1:0]    cap_eff;

   assign busy = (state_ff != S_IDLE);

   assign idx_nxt   = idx_ff + 1'b1;
   assign hit       = (rd_data_ff.key == key_ff);
   assign last      = (idx_nxt == total_ff);
   assign sum       = 9'(rd_data_ff.count) + 9'(amt_ff);
   assign sum_sat   = (sum > 9'(QTY_MAX)) ? QTY_MAX : sum[QTY_W-1:0];
   assign amt_sat   = (amt_ff > AMT_W'(QTY_MAX)) ? QTY_MAX : amt_ff[QTY_W-1:0];
   assign rem_keeps = ({1'b0, rd_data_ff.count} > amt_ff);
   assign rem_diff  = rd_data_ff.count - amt_ff[QTY_W-1:0];
   // after moving entry idx+1 into idx, is there still an entry above idx+1 to pull down
   assign shf_more  = (({1'b0, idx_nxt} + 1'b1) < {1'b0, total_ff});

   // effective capacity is min(capacity, DEPTH)
   assign cap_eff = (XW'(cap_ff) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(cap_ff);
   assign full    = (XW'(total_ff) >= cap_eff);

   // RAM control
   always_comb begin
      rd_addr   = (state_ff == S_SHF_RD) ? idx_nxt[AW-1:0] : idx_ff[AW-1:0];
      mem_we    = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = '{key: key_ff, count: sum_sat};
      case (state_ff)
         S_SRCH_CMP: begin
            if (hit) begin
               if (cmd_ff == CMD_ADD) begin
                  mem_we = 1'b1;
               end else if (cmd_ff == CMD_REMOVE && rem_keeps) begin
                  mem_we          = 1'b1;
                  mem_wdata.count = rem_diff;
               end
            end
         end
         S_MISS: begin
            if (cmd_ff == CMD_ADD && !full) begin
               mem_we    = 1'b1;
               mem_waddr = total_ff[AW-1:0];
               mem_wdata = '{key: key_ff, count: amt_sat};
            end
         end
         S_SHF_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // sequencer and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         total_ff         <= '0;
         idx_ff           <= '0;
         rsp_valid        <= 1'b0;
         rsp_status       <= ST_OK;
         rsp_quantity     <= '0;
         rsp_entries_used <= '0;
         cmd_ff           <= CMD_QUERY;
         key_ff           <= '0;
         amt_ff           <= '0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_command;
                  key_ff   <= req_item_key;
                  amt_ff   <= req_amount;
                  idx_ff   <= '0;
                  state_ff <= (total_ff == '0) ? S_MISS : S_SRCH_RD;
               end
            end
            S_SRCH_RD: begin
               state_ff <= S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
               if (hit) begin
                  case (cmd_ff)
                     CMD_ADD: begin
                        rsp_valid        <= 1'b1;
                        rsp_status       <= ST_OK;
                        rsp_quantity     <= sum_sat;
                        rsp_entries_used <= USED_W'(total_ff);
                        state_ff         <= S_IDLE;
                     end
                     CMD_REMOVE: begin
                        if (rem_keeps) begin
                           rsp_valid        <= 1'b1;
                           rsp_status       <= ST_OK;
                           rsp_quantity     <= rem_diff;
                           rsp_entries_used <= USED_W'(total_ff);
                           state_ff         <= S_IDLE;
                        end else if (!last) begin
                           state_ff <= S_SHF_RD;   // compact from idx upward
                        end else begin
                           // deleting the tail entry, nothing to move
                           total_ff         <= total_ff - 1'b1;
                           rsp_valid        <= 1'b1;
                           rsp_status       <= ST_OK;
                           rsp_quantity     <= '0;
                           rsp_entries_used <= USED_W'(total_ff - 1'b1);
                           state_ff         <= S_IDLE;
                        end
                     end
                     default: begin   // query
                        rsp_valid        <= 1'b1;
                        rsp_status       <= ST_OK;
                        rsp_quantity     <= rd_data_ff.count;
                        rsp_entries_used <= USED_W'(total_ff);
                        state_ff         <= S_IDLE;
                     end
                  endcase
               end else if (last) begin
                  state_ff <= S_MISS;
               end else begin
                  idx_ff   <= idx_nxt;
                  state_ff <= S_SRCH_RD;
               end
            end
            S_MISS: begin
               rsp_valid    <= 1'b1;
               rsp_quantity <= '0;
               rsp_status   <= ST_OK;
               rsp_entries_used <= USED_W'(total_ff);
               case (cmd_ff)
                  CMD_ADD: begin
                     if (full) begin
                        rsp_status <= ST_FULL;
                     end else begin
                        total_ff         <= total_ff + 1'b1;
                        rsp_quantity     <= amt_sat;
                        rsp_entries_used <= USED_W'(total_ff + 1'b1);
                     end
                  end
                  CMD_REMOVE: begin
                     rsp_status <= ST_NOT_FOUND;
                  end
                  default: begin
                  end
               endcase
               state_ff <= S_IDLE;
            end
            S_SHF_RD: begin
               state_ff <= S_SHF_WR;
            end
            S_SHF_WR: begin
               idx_ff <= idx_nxt;
               if (shf_more) begin
                  state_ff <= S_SHF_RD;
               end else begin
                  total_ff         <= total_ff - 1'b1;
                  rsp_valid        <= 1'b1;
                  rsp_status       <= ST_OK;
                  rsp_quantity     <= '0;
                  rsp_entries_used <= USED_W'(total_ff - 1'b1);
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
